FILE: src/wrip_pkg.sv
// ----------------------------------------------------------------------------
// wrip_pkg
// Shared sizes, codes and types of the weighted row inner product unit.
// ----------------------------------------------------------------------------
package wrip_pkg;

  localparam int ROWS      = 256;
  localparam int MAX_BLOCK = 16;

  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = 48;
  localparam int IDX_W     = 8;
  localparam int MODE_W    = 2;
  localparam int BU_W      = 5;
  localparam int CFG_IDX_W = 2;

  // Q30 fraction bits dropped after each multiply
  localparam int FRAC_W    = 30;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int P_W       = PROD_W - FRAC_W;
  localparam int PROD2_W   = P_W + DATA_W;
  localparam int TERM_W    = PROD2_W - FRAC_W;
  // terms plus diagonal offset, with guard bits for MAX_BLOCK up to 64
  localparam int ACC_W     = ENTRY_W + 2;

  localparam int AW        = $clog2(ROWS * MAX_BLOCK);
  localparam int KW        = $clog2(MAX_BLOCK + 1);
  localparam int KIW       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  localparam int Q_DEPTH   = 2;
  localparam int QPW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW       = $clog2(Q_DEPTH + 1);

  localparam logic [BU_W-1:0] BLOCK_USED_RST = BU_W'(16);

  localparam logic [MODE_W-1:0] MODE_WR_BASIS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_WEIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_ADD   = 2'd1;

  typedef enum logic [1:0] {
    OP_WR_BASIS,
    OP_WR_WEIGHT,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } cmd_t;

endpackage

FILE: src/wrip_front.sv
// ----------------------------------------------------------------------------
// wrip_front
// Input side: takes transactions, decodes the mode and pushes commands.
// ----------------------------------------------------------------------------
module wrip_front (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wrip_pkg::MODE_W-1:0]       mode_i,
  input  logic [wrip_pkg::IDX_W-1:0]        row_i,
  input  logic [wrip_pkg::IDX_W-1:0]        col_i,
  input  logic signed [wrip_pkg::DATA_W-1:0] value_i,
  input  logic                              last_query_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output wrip_pkg::cmd_t                    cmd_o
);

  logic known;

  always_comb begin
    known        = 1'b1;
    cmd_o.op     = wrip_pkg::OP_QUERY;
    case (mode_i)
      wrip_pkg::MODE_WR_BASIS:  cmd_o.op = wrip_pkg::OP_WR_BASIS;
      wrip_pkg::MODE_WR_WEIGHT: cmd_o.op = wrip_pkg::OP_WR_WEIGHT;
      wrip_pkg::MODE_QUERY:     cmd_o.op = wrip_pkg::OP_QUERY;
      default:                  known    = 1'b0;
    endcase
    cmd_o.row   = row_i;
    cmd_o.col   = col_i;
    cmd_o.value = value_i;
    cmd_o.last  = last_query_i;
  end

  // unknown modes are taken and dropped here
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && known;

endmodule

FILE: src/wrip_queue.sv
// ----------------------------------------------------------------------------
// wrip_queue
// Short command queue between the decode side and the datapath.
// ----------------------------------------------------------------------------
module wrip_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wrip_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output wrip_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  wrip_pkg::cmd_t              mem_q [wrip_pkg::Q_DEPTH];
  logic [wrip_pkg::QPW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [wrip_pkg::QCW-1:0]    cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == wrip_pkg::QCW'(wrip_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == wrip_pkg::QPW'(wrip_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == wrip_pkg::QPW'(wrip_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/wrip_back.sv
// ----------------------------------------------------------------------------
// wrip_back
// Datapath: table writes, the per-position multiply chain and the result.
// ----------------------------------------------------------------------------
module wrip_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  wrip_pkg::cmd_t                      q_cmd_i,
  output logic                                q_pop_o,
  input  logic                                cfg_valid_i,
  input  logic [wrip_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wrip_pkg::ENTRY_W-1:0]        cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wrip_pkg::ENTRY_W-1:0] entry_o,
  output logic [wrip_pkg::IDX_W-1:0]          entry_row_o,
  output logic [wrip_pkg::IDX_W-1:0]          entry_col_o,
  output logic                                last_o
);

  // configuration
  logic [wrip_pkg::BU_W-1:0]           block_used_q;
  logic signed [wrip_pkg::ENTRY_W-1:0] diag_q;

  // tables
  logic signed [wrip_pkg::DATA_W-1:0] basis_mem [wrip_pkg::ROWS * wrip_pkg::MAX_BLOCK];
  logic signed [wrip_pkg::DATA_W-1:0] weight_q  [wrip_pkg::MAX_BLOCK];

  // sequencer
  logic                        busy_q, iss_q;
  logic [wrip_pkg::KW-1:0]     k_q, n_q, n_cfg;
  logic [wrip_pkg::IDX_W-1:0]  row_q, col_q;
  logic                        last_q, eq_q, rz_q, cz_q;

  // pipeline
  logic                                 v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic signed [wrip_pkg::DATA_W-1:0]   rd_a_q, rd_b_q, w1_q, w2_q, mul_a, mul_b;
  logic signed [wrip_pkg::PROD_W-1:0]   m1_q;
  logic signed [wrip_pkg::P_W-1:0]      p_w;
  logic signed [wrip_pkg::PROD2_W-1:0]  m2_q;
  logic signed [wrip_pkg::TERM_W-1:0]   term;
  logic signed [wrip_pkg::ACC_W-1:0]    acc_q, acc_d, sum;

  logic [wrip_pkg::AW-1:0]  addr_a, addr_b, wr_addr;
  logic                     pop_ok, pop_query, zero_query, basis_we, weight_we, iss_last;
  logic                     res_we, fits;
  logic signed [wrip_pkg::ENTRY_W-1:0] sat_entry, res_entry;

  logic                                out_valid_q;
  logic signed [wrip_pkg::ENTRY_W-1:0] entry_q;
  logic [wrip_pkg::IDX_W-1:0]          entry_row_q, entry_col_q;
  logic                                last_out_q;

  always_comb begin
    // a query starts only with the output register free, so its result never waits
    pop_ok     = !busy_q && q_valid_i &&
                 (q_cmd_i.op != wrip_pkg::OP_QUERY || !out_valid_q || out_ready_i);
    pop_query  = pop_ok && (q_cmd_i.op == wrip_pkg::OP_QUERY);
    n_cfg      = (32'(block_used_q) > wrip_pkg::MAX_BLOCK) ?
                 wrip_pkg::KW'(wrip_pkg::MAX_BLOCK) : wrip_pkg::KW'(block_used_q);
    zero_query = pop_query && (n_cfg == '0);
    wr_addr    = wrip_pkg::AW'(32'(q_cmd_i.row) * wrip_pkg::MAX_BLOCK + 32'(q_cmd_i.col));
    basis_we   = pop_ok && (q_cmd_i.op == wrip_pkg::OP_WR_BASIS) &&
                 (32'(q_cmd_i.row) < wrip_pkg::ROWS) &&
                 (32'(q_cmd_i.col) < wrip_pkg::MAX_BLOCK);
    weight_we  = pop_ok && (q_cmd_i.op == wrip_pkg::OP_WR_WEIGHT) &&
                 (32'(q_cmd_i.col) < wrip_pkg::MAX_BLOCK);
    addr_a     = wrip_pkg::AW'(32'(row_q) * wrip_pkg::MAX_BLOCK + 32'(k_q));
    addr_b     = wrip_pkg::AW'(32'(col_q) * wrip_pkg::MAX_BLOCK + 32'(k_q));
    iss_last   = (k_q + 1'b1) == n_q;

    mul_a = rz_q ? '0 : rd_a_q;
    mul_b = cz_q ? '0 : rd_b_q;
    // arithmetic shifts: truncation toward minus infinity
    p_w   = m1_q[wrip_pkg::PROD_W-1:wrip_pkg::FRAC_W];
    term  = m2_q[wrip_pkg::PROD2_W-1:wrip_pkg::FRAC_W];
    acc_d = acc_q + wrip_pkg::ACC_W'(term);
    sum   = acc_d + (eq_q ? wrip_pkg::ACC_W'(diag_q) : '0);

    fits      = (&sum[wrip_pkg::ACC_W-1:wrip_pkg::ENTRY_W-1]) ||
                !(|sum[wrip_pkg::ACC_W-1:wrip_pkg::ENTRY_W-1]);
    sat_entry = fits ? sum[wrip_pkg::ENTRY_W-1:0] :
                {sum[wrip_pkg::ACC_W-1], {(wrip_pkg::ENTRY_W-1){!sum[wrip_pkg::ACC_W-1]}}};
    res_we    = (v3_q && l3_q) || zero_query;
    res_entry = zero_query ?
                ((q_cmd_i.row == q_cmd_i.col) ? diag_q : '0) : sat_entry;
  end

  assign q_pop_o = pop_ok;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_used_q <= wrip_pkg::BLOCK_USED_RST;
      diag_q       <= '0;
      busy_q       <= 1'b0;
      iss_q        <= 1'b0;
      k_q          <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wrip_pkg::REG_BLOCK_USED: block_used_q <= cfg_data_i[wrip_pkg::BU_W-1:0];
          wrip_pkg::REG_DIAG_ADD:   diag_q       <= cfg_data_i;
          default:                  ;
        endcase
      end
      if (pop_query && !zero_query) begin
        busy_q <= 1'b1;
        iss_q  <= 1'b1;
        k_q    <= '0;
      end else if (iss_q) begin
        k_q <= k_q + 1'b1;
        if (iss_last) begin
          iss_q <= 1'b0;
        end
      end
      if (v3_q && l3_q) begin
        busy_q <= 1'b0;
      end
      v1_q <= iss_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop_query) begin
      n_q    <= n_cfg;
      row_q  <= q_cmd_i.row;
      col_q  <= q_cmd_i.col;
      last_q <= q_cmd_i.last;
      eq_q   <= (q_cmd_i.row == q_cmd_i.col);
      rz_q   <= (32'(q_cmd_i.row) >= wrip_pkg::ROWS);
      cz_q   <= (32'(q_cmd_i.col) >= wrip_pkg::ROWS);
      acc_q  <= '0;
    end else if (v3_q) begin
      acc_q  <= acc_d;
    end
    if (weight_we) begin
      weight_q[q_cmd_i.col[wrip_pkg::KIW-1:0]] <= q_cmd_i.value;
    end
    l1_q <= iss_last;
    l2_q <= l1_q;
    l3_q <= l2_q;
    w2_q <= w1_q;
    m1_q <= wrip_pkg::PROD_W'(mul_a) * wrip_pkg::PROD_W'(mul_b);
    m2_q <= wrip_pkg::PROD2_W'(p_w) * wrip_pkg::PROD2_W'(w2_q);
    if (res_we) begin
      entry_q     <= res_entry;
      entry_row_q <= zero_query ? q_cmd_i.row : row_q;
      entry_col_q <= zero_query ? q_cmd_i.col : col_q;
      last_out_q  <= zero_query ? q_cmd_i.last : last_q;
    end
  end

  // basis memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (basis_we) begin
      basis_mem[wr_addr] <= q_cmd_i.value;
    end
    if (iss_q) begin
      rd_a_q <= basis_mem[addr_a];
      rd_b_q <= basis_mem[addr_b];
      w1_q   <= weight_q[k_q[wrip_pkg::KIW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_o     = entry_q;
  assign entry_row_o = entry_row_q;
  assign entry_col_o = entry_col_q;
  assign last_o      = last_out_q;

`ifndef ASSERT_OFF
  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending transaction");

  a_pipe_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss_q || v1_q || v2_q || v3_q) |-> busy_q)
    else $error("datapath active outside a query");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q |-> (k_q < n_q))
    else $error("basis position beyond block size");

  a_query_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(iss_q) |-> ##3 !busy_q)
    else $error("query did not finish after last issue");
`endif

endmodule

FILE: src/weighted_row_inner_product_unit.sv
// ----------------------------------------------------------------------------
// weighted_row_inner_product_unit
// Weighted inner product of two basis table rows, with diagonal offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): mode 0 writes basis[row][col],
//   mode 1 writes weight[col], mode 2 queries (row, col); mode 3 is dropped.
//   Output channel (out_valid_o/out_ready_i): one transaction per query with
//   the saturated Q17.30 entry and the echoed row, col and last flag.
//   Config channel (cfg_valid_i/cfg_ready_o, always ready): index 0 is
//   block_used, index 1 is diag_add; write only while the block is idle.
// Timing:
//   A query with n = min(block_used, MAX_BLOCK) occupies the datapath and
//   issues one basis position per cycle through the dual-read basis memory,
//   then passes the read, two multiply and one accumulate stages.
//   A two-entry command queue keeps taking transactions, until it is full,
//   while the datapath works or while a result waits in the output register.
// Reset: clears the control state, block_used to 16, diag_add to 0; tables
//   hold no defined value until written. A stalled receiver holds the result
//   and the next query waits; writes queued behind it wait as well, in order.
// ----------------------------------------------------------------------------
module weighted_row_inner_product_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wrip_pkg::MODE_W-1:0]         mode_i,
  input  logic [wrip_pkg::IDX_W-1:0]          row_i,
  input  logic [wrip_pkg::IDX_W-1:0]          col_i,
  input  logic signed [wrip_pkg::DATA_W-1:0]  value_i,
  input  logic                                last_query_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wrip_pkg::ENTRY_W-1:0] entry_o,
  output logic [wrip_pkg::IDX_W-1:0]          entry_row_o,
  output logic [wrip_pkg::IDX_W-1:0]          entry_col_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wrip_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wrip_pkg::ENTRY_W-1:0]        cfg_data_i
);

  logic           push, q_full, q_valid, q_pop;
  wrip_pkg::cmd_t push_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  wrip_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .last_query_i (last_query_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  wrip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  wrip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .entry_o     (entry_o),
    .entry_row_o (entry_row_o),
    .entry_col_o (entry_col_o),
    .last_o      (last_o)
  );

endmodule
